// File: sv/utf8_validating_decoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Assertion macros for the UTF-8 validating decoder port checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATING_DECODER_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UVD_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UVD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/utf8vd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder package
// Widths, status codes, code point limits and lead byte helpers.
// ----------------------------------------------------------------------------
package utf8vd_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int CP_WIDTH   = 21;
   localparam int ST_WIDTH   = 2;
   localparam int LEN_WIDTH  = 3;

   localparam logic [ST_WIDTH-1:0] ST_OK       = 2'd0;
   localparam logic [ST_WIDTH-1:0] ST_BAD_ENC  = 2'd1;
   localparam logic [ST_WIDTH-1:0] ST_TRUNC    = 2'd2;
   localparam logic [ST_WIDTH-1:0] ST_BAD_CHAR = 2'd3;

   localparam logic [CP_WIDTH-1:0] MIN_CP_LEN2 = 21'h000080;
   localparam logic [CP_WIDTH-1:0] MIN_CP_LEN3 = 21'h000800;
   localparam logic [CP_WIDTH-1:0] MIN_CP_LEN4 = 21'h010000;
   localparam logic [CP_WIDTH-1:0] MAX_CP      = 21'h10FFFF;
   localparam logic [CP_WIDTH-1:0] NONCHAR_LO  = 21'h00FDD0;
   localparam logic [CP_WIDTH-1:0] NONCHAR_HI  = 21'h00FDEF;
   localparam logic [CP_WIDTH-1:0] SURR_LO     = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURR_HI     = 21'h00DFFF;
   localparam logic [15:0]         PLANE_END   = 16'hFFFE;

   // Sequence length announced by a lead byte; zero for a byte that cannot lead.
   function automatic logic [LEN_WIDTH-1:0] lead_length(input logic [BYTE_WIDTH-1:0] b);
      logic [LEN_WIDTH-1:0] len;
      len = 3'd0;
      if (b[7] == 1'b0) begin
         len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end
      return len;
   endfunction

   // Value bits that a lead byte of the given length carries.
   function automatic logic [BYTE_WIDTH-1:0] lead_bits(input logic [BYTE_WIDTH-1:0] b,
                                                       input logic [LEN_WIDTH-1:0] len);
      logic [BYTE_WIDTH-1:0] bits;
      case (len)
         3'd2:    bits = b & 8'h1F;
         3'd3:    bits = b & 8'h0F;
         default: bits = b & 8'h07;
      endcase
      return bits;
   endfunction

   function automatic logic [CP_WIDTH-1:0] overlong_min(input logic [LEN_WIDTH-1:0] len);
      logic [CP_WIDTH-1:0] lim;
      case (len)
         3'd2:    lim = MIN_CP_LEN2;
         3'd3:    lim = MIN_CP_LEN3;
         default: lim = MIN_CP_LEN4;
      endcase
      return lim;
   endfunction

   function automatic logic invalid_char(input logic [CP_WIDTH-1:0] c);
      return (c >= SURR_LO && c <= SURR_HI) ||
             (c >= NONCHAR_LO && c <= NONCHAR_HI) ||
             ((c[15:0] & PLANE_END) == PLANE_END) ||
             (c > MAX_CP);
   endfunction

endpackage

// File: sv/utf8_validating_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder
// Decodes a byte stream into code points, flagging bad encodings,
// truncated sequences and invalid characters.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Word
//  req_    | in        | req_valid/stall    | data_byte, end_of_text
//  rsp_    | out       | rsp_valid/stall    | code_point, status, bytes_used
//
// One word is taken per cycle while the input is not stalled; a word is held in the
// input register and any result it completes is registered in the result register.
// The decode is a single pass over the input register and the sequence state.
// Reset is synchronous and closes any open sequence.
// A held result stalls the input only once the input register is also full.
// ----------------------------------------------------------------------------
module utf8_validating_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [utf8vd_pkg::BYTE_WIDTH-1:0]    req_data_byte,
   input  logic                                 req_end_of_text,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [utf8vd_pkg::CP_WIDTH-1:0]      rsp_code_point,
   output logic [utf8vd_pkg::ST_WIDTH-1:0]      rsp_status,
   output logic [utf8vd_pkg::LEN_WIDTH-1:0]     rsp_bytes_used
);
   import utf8vd_pkg::*;

   logic                   stg_valid_ff, stg_valid_in;
   logic [BYTE_WIDTH-1:0]  stg_byte_ff;
   logic                   stg_eot_ff;

   logic [CP_WIDTH-1:0]    payload_ff, payload_in;
   logic [LEN_WIDTH-1:0]   exp_len_ff, exp_len_in;
   logic [LEN_WIDTH-1:0]   seen_ff, seen_in;
   logic                   fault_ff, fault_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CP_WIDTH-1:0]    rsp_cp_ff;
   logic [ST_WIDTH-1:0]    rsp_status_ff;
   logic [LEN_WIDTH-1:0]   rsp_used_ff;

   logic                   advance;
   logic                   seq_open;
   logic [LEN_WIDTH-1:0]   lead_len;
   logic [CP_WIDTH-1:0]    pay_acc;
   logic [LEN_WIDTH-1:0]   seen_acc;
   logic                   fault_acc;
   logic                   res_fire;
   logic [CP_WIDTH-1:0]    res_cp;
   logic [ST_WIDTH-1:0]    res_status;
   logic [LEN_WIDTH-1:0]   res_used;

   assign advance      = stg_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = stg_valid_ff && !advance;
   assign stg_valid_in = req_stall ? stg_valid_ff : req_valid;

   assign seq_open = (exp_len_ff >= 3'd2) && (exp_len_ff <= 3'd4) &&
                     (seen_ff != 3'd0) && (seen_ff < exp_len_ff);
   assign lead_len  = lead_length(stg_byte_ff);
   assign pay_acc   = {payload_ff[CP_WIDTH-7:0], stg_byte_ff[5:0]};
   assign seen_acc  = LEN_WIDTH'(seen_ff + 3'd1);
   assign fault_acc = fault_ff || (stg_byte_ff[7:6] != 2'b10);

   always_comb begin
      payload_in = payload_ff;
      exp_len_in = exp_len_ff;
      seen_in    = seen_ff;
      fault_in   = fault_ff;
      res_fire   = 1'b0;
      res_cp     = '0;
      res_status = ST_OK;
      res_used   = 3'd1;
      if (!seq_open) begin
         // No sequence open: this word is a lead byte.
         payload_in = '0;
         exp_len_in = '0;
         seen_in    = '0;
         fault_in   = 1'b0;
         if (lead_len == 3'd1) begin
            res_fire = 1'b1;
            res_cp   = CP_WIDTH'(stg_byte_ff);
         end else if (lead_len == 3'd0) begin
            res_fire   = 1'b1;
            res_status = ST_BAD_ENC;
         end else if (stg_eot_ff) begin
            res_fire   = 1'b1;
            res_status = ST_TRUNC;
         end else begin
            payload_in = CP_WIDTH'(lead_bits(stg_byte_ff, lead_len));
            exp_len_in = lead_len;
            seen_in    = 3'd1;
         end
      end else if (seen_acc < exp_len_ff) begin
         if (stg_eot_ff) begin
            // Truncation wins over any bad tail seen so far.
            payload_in = '0;
            exp_len_in = '0;
            seen_in    = '0;
            fault_in   = 1'b0;
            res_fire   = 1'b1;
            res_status = ST_TRUNC;
            res_used   = seen_acc;
         end else begin
            payload_in = pay_acc;
            seen_in    = seen_acc;
            fault_in   = fault_acc;
         end
      end else begin
         payload_in = '0;
         exp_len_in = '0;
         seen_in    = '0;
         fault_in   = 1'b0;
         res_fire   = 1'b1;
         res_used   = exp_len_ff;
         if (fault_acc || (pay_acc < overlong_min(exp_len_ff))) begin
            res_status = ST_BAD_ENC;
         end else if (invalid_char(pay_acc)) begin
            res_status = ST_BAD_CHAR;
            res_cp     = pay_acc;
         end else begin
            res_cp = pay_acc;
         end
      end
   end

   assign rsp_valid_in = advance ? res_fire : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         payload_ff   <= '0;
         exp_len_ff   <= '0;
         seen_ff      <= '0;
         fault_ff     <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            payload_ff <= payload_in;
            exp_len_ff <= exp_len_in;
            seen_ff    <= seen_in;
            fault_ff   <= fault_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stg_byte_ff <= req_data_byte;
         stg_eot_ff  <= req_end_of_text;
      end
      if (advance && res_fire) begin
         rsp_cp_ff     <= res_cp;
         rsp_status_ff <= res_status;
         rsp_used_ff   <= res_used;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_cp_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_bytes_used = rsp_used_ff;

endmodule

// File: sv/utf8vd_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the decoder's result port and flags words that break its rules.
// ----------------------------------------------------------------------------
module utf8vd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [utf8vd_pkg::CP_WIDTH-1:0]      rsp_code_point,
   input logic [utf8vd_pkg::ST_WIDTH-1:0]      rsp_status,
   input logic [utf8vd_pkg::LEN_WIDTH-1:0]     rsp_bytes_used
);
   import utf8vd_pkg::*;

`include "utf8_validating_decoder_assert.svh"

   // A stalled result word holds until it is taken.
`UVD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
   rsp_valid && $stable(rsp_code_point) && $stable(rsp_status) && $stable(rsp_bytes_used),
   "stalled result word changed")

   // Rejected or cut-off sequences never carry a value.
`UVD_ASSERT_SAME(a_zero_on_error, clock, reset,
   rsp_valid && (rsp_status == ST_BAD_ENC || rsp_status == ST_TRUNC),
   rsp_code_point == '0, "error word carries a code point")

   // Every result consumed between one and four bytes.
`UVD_ASSERT_SAME(a_used_range, clock, reset, rsp_valid,
   rsp_bytes_used >= 3'd1 && rsp_bytes_used <= 3'd4, "bytes used out of range")

   // A one-byte good character is plain ASCII.
`UVD_ASSERT_SAME(a_ascii_short, clock, reset,
   rsp_valid && rsp_status == ST_OK && rsp_bytes_used == 3'd1,
   rsp_code_point < MIN_CP_LEN2, "one-byte character above ASCII")

endmodule

bind utf8_validating_decoder utf8vd_checker u_utf8vd_checker (.*);

// File: test/utf8_decode_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder checker
// Watches both channels of the decoder, predicts the result of every accepted
// byte and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_decode_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [utf8vd_pkg::BYTE_WIDTH-1:0] req_data_byte,
   input  logic                              req_end_of_text,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [utf8vd_pkg::CP_WIDTH-1:0]   rsp_code_point,
   input  logic [utf8vd_pkg::ST_WIDTH-1:0]   rsp_status,
   input  logic [utf8vd_pkg::LEN_WIDTH-1:0]  rsp_bytes_used,
   output int                                fault_count,
   output int                                chars_pending
);
   import utf8vd_pkg::*;

   typedef struct packed {
      logic [CP_WIDTH-1:0]  code_point;
      logic [ST_WIDTH-1:0]  status;
      logic [LEN_WIDTH-1:0] bytes_used;
   } char_result_type;

   char_result_type      expected_chars[$];
   logic [CP_WIDTH-1:0]  acc_value;
   logic [LEN_WIDTH-1:0] seq_len = '0;
   logic [LEN_WIDTH-1:0] seq_taken;
   logic                 seq_bad_tail;

   initial fault_count = 0;
   initial chars_pending = 0;

   // Advances the predicted decoder state by one byte and queues any result it completes.
   task automatic decode_byte(input logic [BYTE_WIDTH-1:0] b, input logic last);
      char_result_type      res;
      logic                 has_res;
      logic [LEN_WIDTH-1:0] len;
      logic [CP_WIDTH-1:0]  floor;
      has_res = 1'b0;
      res = '0;
      if (seq_len == '0) begin
         casez (b)
            8'b0???????: len = 3'd1;
            8'b110?????: len = 3'd2;
            8'b1110????: len = 3'd3;
            8'b11110???: len = 3'd4;
            default:     len = 3'd0;
         endcase
         has_res = 1'b1;
         res.bytes_used = 3'd1;
         if (len == 3'd1) begin
            res.code_point = CP_WIDTH'(b);
            res.status = ST_OK;
         end else if (len == 3'd0) begin
            res.status = ST_BAD_ENC;
         end else if (last) begin
            res.status = ST_TRUNC;
         end else begin
            has_res = 1'b0;
            acc_value = CP_WIDTH'(b & (8'h7F >> len));
            seq_len = len;
            seq_taken = 3'd1;
            seq_bad_tail = 1'b0;
         end
      end else begin
         acc_value = {acc_value[CP_WIDTH-7:0], b[5:0]};
         if (b[7:6] != 2'b10) seq_bad_tail = 1'b1;
         seq_taken = seq_taken + 3'd1;
         if (seq_taken < seq_len) begin
            // Truncation wins over a bad tail seen so far.
            if (last) begin
               has_res = 1'b1;
               res.status = ST_TRUNC;
               res.bytes_used = seq_taken;
               seq_len = '0;
            end
         end else begin
            case (seq_len)
               3'd2:    floor = MIN_CP_LEN2;
               3'd3:    floor = MIN_CP_LEN3;
               default: floor = MIN_CP_LEN4;
            endcase
            has_res = 1'b1;
            res.bytes_used = seq_len;
            if (seq_bad_tail || acc_value < floor) begin
               res.status = ST_BAD_ENC;
            end else begin
               res.code_point = acc_value;
               if ((acc_value >= SURR_LO && acc_value <= SURR_HI) ||
                   (acc_value >= NONCHAR_LO && acc_value <= NONCHAR_HI) ||
                   acc_value[15:1] == 15'h7FFF || acc_value > MAX_CP) begin
                  res.status = ST_BAD_CHAR;
               end else begin
                  res.status = ST_OK;
               end
            end
            seq_len = '0;
         end
      end
      if (has_res) expected_chars.push_back(res);
   endtask

   always @(posedge clock) begin
      char_result_type want;
      if (reset) begin
         seq_len = '0;
         expected_chars.delete();
      end else begin
         // A result never leaves in the cycle its byte enters, so check first.
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected result: code_point %h status %0d bytes_used %0d",
                      rsp_code_point, rsp_status, rsp_bytes_used);
               fault_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_code_point !== want.code_point) begin
                  $error("code_point: expected %h, got %h", want.code_point, rsp_code_point);
                  fault_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fault_count++;
               end
               if (rsp_bytes_used !== want.bytes_used) begin
                  $error("bytes_used: expected %0d, got %0d", want.bytes_used, rsp_bytes_used);
                  fault_count++;
               end
            end
         end
         if (req_valid && !req_stall) decode_byte(req_data_byte, req_end_of_text);
      end
      chars_pending <= expected_chars.size();
   end

endmodule

// File: test/tb_utf8_validating_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder testbench
// Feeds directed and random byte streams, well-formed characters as well as
// corrupted, overlong and truncated ones, under varying idle patterns on both
// channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_utf8_validating_decoder;
   import utf8vd_pkg::*;

   localparam int RANDOM_BYTES   = 1150;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_WIDTH-1:0] req_data_byte = '0;
   logic                  req_end_of_text = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CP_WIDTH-1:0]   rsp_code_point;
   logic [ST_WIDTH-1:0]   rsp_status;
   logic [LEN_WIDTH-1:0]  rsp_bytes_used;

   int fault_count;
   int chars_pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int sent_count = 0;
   int idle_cycles = 0;

   // Opening text, one entry per word as {end_of_text, data_byte}.
   logic [8:0] opening_text [27] = '{
      9'h000, 9'h17F,                   // ASCII extremes, the second ending the text
      9'h080, 9'h0FF,                   // bytes that cannot lead
      9'h0C2, 9'h0A9,                   // two-byte character
      9'h0F0, 9'h09F, 9'h098, 9'h080,   // four-byte character
      9'h0C0, 9'h080,                   // overlong form
      9'h0ED, 9'h0A0, 9'h080,           // surrogate
      9'h0EF, 9'h0BF, 9'h0BE,           // end of the basic plane
      9'h0F4, 9'h090, 9'h080, 9'h080,   // above the last code point
      9'h1E0,                           // lead byte ending the text
      9'h0E1, 9'h141,                   // bad tail cut off by end of text
      9'h0C3, 9'h041                    // bad tail in a complete sequence
   };

   always #1 clock = ~clock;

   utf8_validating_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_status      (rsp_status),
      .rsp_bytes_used  (rsp_bytes_used)
   );

   utf8_decode_checker decode_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_status      (rsp_status),
      .rsp_bytes_used  (rsp_bytes_used),
      .fault_count     (fault_count),
      .chars_pending   (chars_pending)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_text <= last;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // Holds the input back until every predicted result has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (chars_pending != 0);
   endtask

   // Sends either a noise word or one character, which may be made overlong,
   // given a bad tail byte or cut short by the end of the text.
   task automatic send_random_char();
      logic [CP_WIDTH-1:0]   cp;
      logic [BYTE_WIDTH-1:0] seq [4];
      logic                  eot;
      int                    len;
      int                    cut;
      int                    bad_at;
      int                    i;
      if ($urandom_range(99) < 30) begin
         send_byte(BYTE_WIDTH'($urandom_range(255)), $urandom_range(9) == 0);
      end else begin
         len = $urandom_range(4, 1);
         case (len)
            1: cp = CP_WIDTH'($urandom_range(8'h7F));
            2: cp = CP_WIDTH'($urandom_range(12'h7FF, 8'h80));
            3: case ($urandom_range(7))
                  0:       cp = CP_WIDTH'($urandom_range(16'hDFFF, 16'hD800));
                  1:       cp = CP_WIDTH'($urandom_range(16'hFDEF, 16'hFDD0));
                  2:       cp = {5'd0, 15'h7FFF, 1'($urandom_range(1))};
                  default: cp = CP_WIDTH'($urandom_range(16'hFFFF, 12'h800));
               endcase
            default: case ($urandom_range(7))
                  0:       cp = CP_WIDTH'($urandom_range(21'h1FFFFF, 21'h110000));
                  1:       cp = {5'($urandom_range(16, 1)), 15'h7FFF, 1'($urandom_range(1))};
                  default: cp = CP_WIDTH'($urandom_range(21'h10FFFF, 21'h10000));
               endcase
         endcase
         // A longer form than needed still holds every value bit.
         if (len < 4 && $urandom_range(9) == 0) len = len + $urandom_range(4 - len, 1);
         case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
               seq[0] = {3'b110, cp[10:6]};
               seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
               seq[0] = {4'b1110, cp[15:12]};
               seq[1] = {2'b10, cp[11:6]};
               seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
               seq[0] = {5'b11110, cp[20:18]};
               seq[1] = {2'b10, cp[17:12]};
               seq[2] = {2'b10, cp[11:6]};
               seq[3] = {2'b10, cp[5:0]};
            end
         endcase
         if (len > 1 && $urandom_range(9) == 0) begin
            bad_at = $urandom_range(len - 1, 1);
            do seq[bad_at][7:6] = 2'($urandom_range(3)); while (seq[bad_at][7:6] == 2'b10);
         end
         if (len > 1 && $urandom_range(99) < 8) begin
            cut = $urandom_range(len - 1, 1);
            eot = 1'b1;
         end else begin
            cut = len;
            eot = ($urandom_range(19) == 0);
         end
         for (i = 0; i < cut; i++) send_byte(seq[i], (i == cut - 1) && eot);
      end
   endtask

   initial begin
      int phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 33;
      recv_idle_pct <= 63;
      foreach (opening_text[i]) send_byte(opening_text[i][7:0], opening_text[i][8]);
      wait_for_results();
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct <= 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct <= 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         while (sent_count < $size(opening_text) + (phase + 1) * RANDOM_BYTES / 3) begin
            send_random_char();
         end
         wait_for_results();
      end
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/utf8vd_pkg.sv
sv/utf8_validating_decoder.sv
sv/utf8vd_checker.sv
test/utf8_decode_checker.sv
test/tb_utf8_validating_decoder.sv
